// ===== hw/rtl/pgv_pkg.sv =====
// ----------------------------------------------------------------------------
// pgv_pkg - shared types and constants for the pairwise gravity update
// Request and result records, field widths and saturation limits.
// ----------------------------------------------------------------------------
package pgv_pkg;

    // Field and datapath widths
    localparam int unsigned WORD_W  = 32;  // Q16.16 field
    localparam int unsigned SQ_W    = 65;  // squared separation, Q32.32
    localparam int unsigned ROOT_W  = 33;  // separation, Q16.16
    localparam int unsigned DSQ_W   = 66;  // separation squared after the root
    localparam int unsigned PROD_W  = 96;  // gain * m1 * m2 and force * |e|
    localparam int unsigned FORCE_W = 64;  // force, saturated
    localparam int unsigned COMP_W  = 33;  // force component, capped at 2^32

    localparam logic [WORD_W-1:0] GAIN_RESET = 32'h0001_0000;
    localparam logic [COMP_W-1:0] COMP_MAX   = 33'h1_0000_0000;
    localparam logic [WORD_W-1:0] VEL_MAX    = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] VEL_MIN    = 32'h8000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] first_pos_x;
        logic signed [WORD_W-1:0] first_pos_y;
        logic signed [WORD_W-1:0] second_pos_x;
        logic signed [WORD_W-1:0] second_pos_y;
        logic signed [WORD_W-1:0] first_vel_x;
        logic signed [WORD_W-1:0] first_vel_y;
        logic signed [WORD_W-1:0] second_vel_x;
        logic signed [WORD_W-1:0] second_vel_y;
        logic        [WORD_W-1:0] first_mass;
        logic        [WORD_W-1:0] second_mass;
        logic        [WORD_W-1:0] first_radius;
        logic        [WORD_W-1:0] second_radius;
    } t_pgv_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_first_vel_x;
        logic signed [WORD_W-1:0] new_first_vel_y;
        logic signed [WORD_W-1:0] new_second_vel_x;
        logic signed [WORD_W-1:0] new_second_vel_y;
        logic                     touching;
        logic                     coincident;
    } t_pgv_out;

endpackage

// ===== hw/rtl/pgv_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// pgv_sqrt_pipe - pipelined integer square root
// One root bit per stage, remainder method; a side word travels alongside.
// ----------------------------------------------------------------------------
module pgv_sqrt_pipe #(
    parameter int unsigned PW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [pgv_pkg::SQ_W-1:0]    i_rad,
    input  logic [PW-1:0]               i_side,
    output logic                        o_valid,
    output logic [pgv_pkg::ROOT_W-1:0]  o_root,
    output logic [PW-1:0]               o_side
);
    import pgv_pkg::*;

    localparam int unsigned REM_W = 2 * ROOT_W + 1;

    logic              c_val   [ROOT_W];
    logic [REM_W-1:0]  c_rem   [ROOT_W];
    logic [ROOT_W-1:0] c_root  [ROOT_W];
    logic [PW-1:0]     c_side  [ROOT_W];
    logic [REM_W-1:0]  trial   [ROOT_W];
    logic [REM_W-1:0]  n_rem   [ROOT_W];
    logic [ROOT_W-1:0] n_root  [ROOT_W];

    logic              r_val   [ROOT_W];
    logic [REM_W-1:0]  r_rem   [ROOT_W];
    logic [ROOT_W-1:0] r_root  [ROOT_W];
    logic [PW-1:0]     r_side  [ROOT_W];

    // Select each stage's input: the ports for the first, the stage before otherwise
    always_comb begin
        c_val[0]  = i_valid;
        c_rem[0]  = REM_W'(i_rad);
        c_root[0] = '0;
        c_side[0] = i_side;
        for (int k = 1; k < ROOT_W; k++) begin
            c_val[k]  = r_val[k-1];
            c_rem[k]  = r_rem[k-1];
            c_root[k] = r_root[k-1];
            c_side[k] = r_side[k-1];
        end
    end

    // Try the next root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            trial[k] = (REM_W'(c_root[k]) << (ROOT_W - k))
                     | (REM_W'(1) << (2 * (ROOT_W - 1 - k)));
            n_rem[k]  = c_rem[k];
            n_root[k] = c_root[k];
            if (c_rem[k] >= trial[k]) begin
                n_rem[k]  = c_rem[k] - trial[k];
                n_root[k] = c_root[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) r_val[k] <= 1'b0;
        end else begin
            for (int k = 0; k < ROOT_W; k++) r_val[k] <= c_val[k];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ROOT_W; k++) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_side[k] <= c_side[k];
        end
    end

    assign o_valid = r_val[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// ===== hw/rtl/pgv_div_pipe.sv =====
// ----------------------------------------------------------------------------
// pgv_div_pipe - pipelined restoring divider
// One quotient bit per stage. The starting remainder must lie below the
// divisor; a side word travels alongside.
// ----------------------------------------------------------------------------
module pgv_div_pipe #(
    parameter int unsigned DW = 33,
    parameter int unsigned QW = 33,
    parameter int unsigned PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_div,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_side
);

    logic          c_val  [QW];
    logic [DW-1:0] c_rem  [QW];
    logic [QW-1:0] c_num  [QW];
    logic [DW-1:0] c_div  [QW];
    logic [QW-1:0] c_quo  [QW];
    logic [PW-1:0] c_side [QW];
    logic [DW:0]   trial  [QW];
    logic [DW-1:0] n_rem  [QW];
    logic [QW-1:0] n_quo  [QW];

    logic          r_val  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_num  [QW];
    logic [DW-1:0] r_div  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [PW-1:0] r_side [QW];

    // Select each stage's input
    always_comb begin
        c_val[0]  = i_valid;
        c_rem[0]  = i_rem;
        c_num[0]  = i_num;
        c_div[0]  = i_div;
        c_quo[0]  = '0;
        c_side[0] = i_side;
        for (int k = 1; k < QW; k++) begin
            c_val[k]  = r_val[k-1];
            c_rem[k]  = r_rem[k-1];
            c_num[k]  = r_num[k-1];
            c_div[k]  = r_div[k-1];
            c_quo[k]  = r_quo[k-1];
            c_side[k] = r_side[k-1];
        end
    end

    // Shift in the next numerator bit and subtract where the divisor fits
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            trial[k] = {c_rem[k], c_num[k][QW-1-k]};
            n_rem[k] = trial[k][DW-1:0];
            n_quo[k] = c_quo[k];
            if (trial[k] >= {1'b0, c_div[k]}) begin
                n_rem[k]          = DW'(trial[k] - {1'b0, c_div[k]});
                n_quo[k][QW-1-k]  = 1'b1;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_val[k] <= 1'b0;
        end else begin
            for (int k = 0; k < QW; k++) r_val[k] <= c_val[k];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            r_rem[k]  <= n_rem[k];
            r_num[k]  <= c_num[k];
            r_div[k]  <= c_div[k];
            r_quo[k]  <= n_quo[k];
            r_side[k] <= c_side[k];
        end
    end

    assign o_valid = r_val[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== hw/rtl/pairwise_gravity_velocity_update.sv =====
// ----------------------------------------------------------------------------
// pairwise_gravity_velocity_update - gravity kick for one pair of 2D bodies
// Separation, root, force G*m1*m2/d^2, split along the separation and
// applied to both velocities with saturation; touching and coincident flags.
//
//   port           direction  contents
//   start / busy   in / out   request strobe, taken when busy is low
//   i_req          in         t_pgv_in, both bodies
//   i_cfg_we       in         write strobe for gravity_gain
//   i_cfg_wdata    in         gravity_gain, unsigned Q16.16
//   o_strobe       out        result valid for exactly one cycle
//   o_res          out        t_pgv_out, new velocities and flags
//
// A request enters every cycle and passes through the bit-per-stage
// units: 33 root stages, 64 force quotient stages and 33 component quotient
// stages, plus 10 arithmetic stages. busy is high only during reset. Reset
// empties the pipeline and restores gravity_gain to 1.0; requests in flight
// are dropped. The receiver has no hold-off, so nothing in the pipeline ever
// stalls.
// ----------------------------------------------------------------------------
module pairwise_gravity_velocity_update (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pgv_pkg::t_pgv_in  i_req,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    output logic              o_strobe,
    output pgv_pkg::t_pgv_out o_res
);
    import pgv_pkg::*;

    localparam int unsigned LAT = 4 + ROOT_W + 2 + FORCE_W + 3 + COMP_W + 1;

    typedef struct packed {
        logic [WORD_W-1:0] v1x;
        logic [WORD_W-1:0] v1y;
        logic [WORD_W-1:0] v2x;
        logic [WORD_W-1:0] v2y;
    } t_vel;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic touching;
        logic coincident;
    } t_flags;

    typedef struct packed {
        logic [PROD_W-1:0] gm2;
        logic [WORD_W-1:0] ax;
        logic [WORD_W-1:0] ay;
        t_vel              vel;
        t_flags            flags;
    } t_sq_side;

    typedef struct packed {
        logic              sat;
        logic [ROOT_W-1:0] root_d;
        logic [WORD_W-1:0] ax;
        logic [WORD_W-1:0] ay;
        t_vel              vel;
        t_flags            flags;
    } t_fd_side;

    typedef struct packed {
        logic   cap_x;
        t_vel   vel;
        t_flags flags;
    } t_cd_side;

    // Apply one signed component and saturate to a word
    function automatic logic [WORD_W-1:0] upd_vel(input logic [WORD_W-1:0] v,
                                                  input logic [COMP_W-1:0] c,
                                                  input logic              sub);
        logic [WORD_W+1:0] wide;
        logic [WORD_W+1:0] cc;
        logic [WORD_W+1:0] sum;
        logic [WORD_W-1:0] res;
        wide = {{2{v[WORD_W-1]}}, v};
        cc   = {1'b0, c};
        sum  = sub ? wide - cc : wide + cc;
        if (sum[WORD_W+1:WORD_W-1] == 3'b000 || sum[WORD_W+1:WORD_W-1] == 3'b111) begin
            res = sum[WORD_W-1:0];
        end else if (sum[WORD_W+1]) begin
            res = VEL_MIN;
        end else begin
            res = VEL_MAX;
        end
        return res;
    endfunction

    logic              accept;
    logic [WORD_W-1:0] r_gain;

    // stage 1
    logic              r_s1_val;
    logic [WORD_W-1:0] r_s1_ax, r_s1_ay, r_s1_m1, r_s1_m2;
    logic [WORD_W:0]   r_s1_rsum;
    logic              r_s1_negx, r_s1_negy;
    t_vel              r_s1_vel;
    // stage 2
    logic              r_s2_val;
    logic [2*WORD_W-1:0] r_s2_sxx, r_s2_syy, r_s2_gm;
    logic [DSQ_W-1:0]  r_s2_rsq;
    logic [WORD_W-1:0] r_s2_m2, r_s2_ax, r_s2_ay;
    logic              r_s2_negx, r_s2_negy;
    t_vel              r_s2_vel;
    // stage 3
    logic              r_s3_val;
    logic [SQ_W-1:0]   r_s3_sq;
    logic [2*WORD_W-1:0] r_s3_pkl, r_s3_pkh;
    logic [DSQ_W-1:0]  r_s3_rsq;
    logic [WORD_W-1:0] r_s3_ax, r_s3_ay;
    logic              r_s3_negx, r_s3_negy;
    t_vel              r_s3_vel;
    // stage 4
    logic              r_s4_val;
    logic [SQ_W-1:0]   r_s4_sq;
    t_sq_side          r_s4_side;
    // root
    logic              sq_val;
    logic [ROOT_W-1:0] sq_root;
    t_sq_side          sq_side;
    // stages 5 and 6
    logic              r_s5_val, r_s6_val;
    logic [DSQ_W-1:0]  r_s5_dsq, r_s6_dsq;
    logic [ROOT_W-1:0] r_s5_root, r_s6_root;
    t_sq_side          r_s5_side, r_s6_side;
    logic              r_s6_sat;
    t_fd_side          fd_in_side;
    // force quotient
    logic              fd_val;
    logic [FORCE_W-1:0] fd_quo;
    t_fd_side          fd_side;
    logic [FORCE_W-1:0] frc;
    // stages 7 to 9
    logic              r_s7_val, r_s8_val, r_s9_val;
    logic [2*WORD_W-1:0] r_s7_fxh, r_s7_fxl, r_s7_fyh, r_s7_fyl;
    logic [PROD_W-1:0] r_s8_px, r_s8_py;
    logic              r_s9_capx, r_s9_capy;
    logic [DSQ_W-1:0]  r_s9_px, r_s9_py;
    logic [ROOT_W-1:0] r_s7_root, r_s8_root, r_s9_root;
    t_vel              r_s7_vel, r_s8_vel, r_s9_vel;
    t_flags            r_s7_flags, r_s8_flags, r_s9_flags;
    t_cd_side          cd_in_side;
    // component quotients
    logic              cdx_val, cdy_val;
    logic [COMP_W-1:0] cdx_quo, cdy_quo;
    t_cd_side          cdx_side;
    logic              cdy_cap;
    logic [COMP_W-1:0] cx, cy;
    logic              zero_c;

    // Stage-1 separation terms
    logic [WORD_W:0]   ex, ey, ex_abs, ey_abs;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    assign ex = {i_req.first_pos_x[WORD_W-1], i_req.first_pos_x}
              - {i_req.second_pos_x[WORD_W-1], i_req.second_pos_x};
    assign ey = {i_req.first_pos_y[WORD_W-1], i_req.first_pos_y}
              - {i_req.second_pos_y[WORD_W-1], i_req.second_pos_y};
    assign ex_abs = ex[WORD_W] ? -ex : ex;
    assign ey_abs = ey[WORD_W] ? -ey : ey;

    // Hold the gravity gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // Advance valid bits of the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_val <= 1'b0;
            r_s2_val <= 1'b0;
            r_s3_val <= 1'b0;
            r_s4_val <= 1'b0;
            r_s5_val <= 1'b0;
            r_s6_val <= 1'b0;
            r_s7_val <= 1'b0;
            r_s8_val <= 1'b0;
            r_s9_val <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_s1_val <= accept;
            r_s2_val <= r_s1_val;
            r_s3_val <= r_s2_val;
            r_s4_val <= r_s3_val;
            r_s5_val <= sq_val;
            r_s6_val <= r_s5_val;
            r_s7_val <= fd_val;
            r_s8_val <= r_s7_val;
            r_s9_val <= r_s8_val;
            o_strobe <= cdx_val & cdy_val;
        end
    end

    // Stages 1 to 4: separation, squares, mass product, touch test
    always_ff @(posedge i_clk) begin
        r_s1_ax   <= ex_abs[WORD_W-1:0];
        r_s1_ay   <= ey_abs[WORD_W-1:0];
        r_s1_negx <= ex[WORD_W];
        r_s1_negy <= ey[WORD_W];
        r_s1_rsum <= {1'b0, i_req.first_radius} + {1'b0, i_req.second_radius};
        r_s1_m1   <= i_req.first_mass;
        r_s1_m2   <= i_req.second_mass;
        r_s1_vel  <= '{v1x: i_req.first_vel_x,  v1y: i_req.first_vel_y,
                       v2x: i_req.second_vel_x, v2y: i_req.second_vel_y};

        r_s2_sxx  <= r_s1_ax * r_s1_ax;
        r_s2_syy  <= r_s1_ay * r_s1_ay;
        r_s2_rsq  <= r_s1_rsum * r_s1_rsum;
        r_s2_gm   <= r_gain * r_s1_m1;
        r_s2_m2   <= r_s1_m2;
        r_s2_ax   <= r_s1_ax;
        r_s2_ay   <= r_s1_ay;
        r_s2_negx <= r_s1_negx;
        r_s2_negy <= r_s1_negy;
        r_s2_vel  <= r_s1_vel;

        r_s3_sq   <= SQ_W'(r_s2_sxx) + SQ_W'(r_s2_syy);
        r_s3_pkl  <= r_s2_gm[WORD_W-1:0] * r_s2_m2;
        r_s3_pkh  <= r_s2_gm[2*WORD_W-1:WORD_W] * r_s2_m2;
        r_s3_rsq  <= r_s2_rsq;
        r_s3_ax   <= r_s2_ax;
        r_s3_ay   <= r_s2_ay;
        r_s3_negx <= r_s2_negx;
        r_s3_negy <= r_s2_negy;
        r_s3_vel  <= r_s2_vel;

        r_s4_sq        <= r_s3_sq;
        r_s4_side.gm2  <= (PROD_W'(r_s3_pkh) << WORD_W) + PROD_W'(r_s3_pkl);
        r_s4_side.ax   <= r_s3_ax;
        r_s4_side.ay   <= r_s3_ay;
        r_s4_side.vel  <= r_s3_vel;
        r_s4_side.flags.neg_x      <= r_s3_negx;
        r_s4_side.flags.neg_y      <= r_s3_negy;
        r_s4_side.flags.touching   <= DSQ_W'(r_s3_sq) <= r_s3_rsq;
        r_s4_side.flags.coincident <= r_s3_sq == '0;
    end

    // Separation root
    pgv_sqrt_pipe #(
        .PW ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_val),
        .i_rad   (r_s4_sq),
        .i_side  (r_s4_side),
        .o_valid (sq_val),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stages 5 and 6: square the root, detect force saturation
    always_ff @(posedge i_clk) begin
        r_s5_dsq  <= sq_root * sq_root;
        r_s5_root <= sq_root;
        r_s5_side <= sq_side;

        r_s6_dsq  <= r_s5_dsq;
        r_s6_root <= r_s5_root;
        r_s6_side <= r_s5_side;
        r_s6_sat  <= DSQ_W'(r_s5_side.gm2[PROD_W-1:FORCE_W]) >= r_s5_dsq;
    end

    assign fd_in_side = '{sat: r_s6_sat, root_d: r_s6_root, ax: r_s6_side.ax,
                          ay: r_s6_side.ay, vel: r_s6_side.vel, flags: r_s6_side.flags};

    // Force = gain*m1*m2 / d^2
    pgv_div_pipe #(
        .DW (DSQ_W),
        .QW (FORCE_W),
        .PW ($bits(t_fd_side))
    ) u_force_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s6_val),
        .i_rem   (DSQ_W'(r_s6_side.gm2[PROD_W-1:FORCE_W])),
        .i_num   (r_s6_side.gm2[FORCE_W-1:0]),
        .i_div   (r_s6_dsq),
        .i_side  (fd_in_side),
        .o_valid (fd_val),
        .o_quo   (fd_quo),
        .o_side  (fd_side)
    );

    assign frc = fd_side.sat ? '1 : fd_quo;

    // Stages 7 to 9: force times |e| in halves, sum, cap detection
    always_ff @(posedge i_clk) begin
        r_s7_fxh   <= frc[FORCE_W-1:WORD_W] * fd_side.ax;
        r_s7_fxl   <= frc[WORD_W-1:0] * fd_side.ax;
        r_s7_fyh   <= frc[FORCE_W-1:WORD_W] * fd_side.ay;
        r_s7_fyl   <= frc[WORD_W-1:0] * fd_side.ay;
        r_s7_root  <= fd_side.root_d;
        r_s7_vel   <= fd_side.vel;
        r_s7_flags <= fd_side.flags;

        r_s8_px    <= (PROD_W'(r_s7_fxh) << WORD_W) + PROD_W'(r_s7_fxl);
        r_s8_py    <= (PROD_W'(r_s7_fyh) << WORD_W) + PROD_W'(r_s7_fyl);
        r_s8_root  <= r_s7_root;
        r_s8_vel   <= r_s7_vel;
        r_s8_flags <= r_s7_flags;

        r_s9_capx  <= r_s8_px[PROD_W-1:COMP_W] >= (PROD_W - COMP_W)'(r_s8_root);
        r_s9_capy  <= r_s8_py[PROD_W-1:COMP_W] >= (PROD_W - COMP_W)'(r_s8_root);
        r_s9_px    <= r_s8_px[DSQ_W-1:0];
        r_s9_py    <= r_s8_py[DSQ_W-1:0];
        r_s9_root  <= r_s8_root;
        r_s9_vel   <= r_s8_vel;
        r_s9_flags <= r_s8_flags;
    end

    assign cd_in_side = '{cap_x: r_s9_capx, vel: r_s9_vel, flags: r_s9_flags};

    // Components = force * |e| / d
    pgv_div_pipe #(
        .DW (ROOT_W),
        .QW (COMP_W),
        .PW ($bits(t_cd_side))
    ) u_comp_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s9_val),
        .i_rem   (r_s9_px[DSQ_W-1:COMP_W]),
        .i_num   (r_s9_px[COMP_W-1:0]),
        .i_div   (r_s9_root),
        .i_side  (cd_in_side),
        .o_valid (cdx_val),
        .o_quo   (cdx_quo),
        .o_side  (cdx_side)
    );

    pgv_div_pipe #(
        .DW (ROOT_W),
        .QW (COMP_W),
        .PW (1)
    ) u_comp_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s9_val),
        .i_rem   (r_s9_py[DSQ_W-1:COMP_W]),
        .i_num   (r_s9_py[COMP_W-1:0]),
        .i_div   (r_s9_root),
        .i_side  (r_s9_capy),
        .o_valid (cdy_val),
        .o_quo   (cdy_quo),
        .o_side  (cdy_cap)
    );

    // Cap the components; drop them for coincident bodies
    assign zero_c = cdx_side.flags.coincident;
    assign cx = zero_c ? '0 : ((cdx_side.cap_x || cdx_quo > COMP_MAX) ? COMP_MAX : cdx_quo);
    assign cy = zero_c ? '0 : ((cdy_cap || cdy_quo > COMP_MAX) ? COMP_MAX : cdy_quo);

    // Stage 10: apply components and register the result
    always_ff @(posedge i_clk) begin
        o_res.new_first_vel_x  <= upd_vel(cdx_side.vel.v1x, cx, ~cdx_side.flags.neg_x);
        o_res.new_second_vel_x <= upd_vel(cdx_side.vel.v2x, cx,  cdx_side.flags.neg_x);
        o_res.new_first_vel_y  <= upd_vel(cdx_side.vel.v1y, cy, ~cdx_side.flags.neg_y);
        o_res.new_second_vel_y <= upd_vel(cdx_side.vel.v2y, cy,  cdx_side.flags.neg_y);
        o_res.touching         <= cdx_side.flags.touching;
        o_res.coincident       <= cdx_side.flags.coincident;
    end

    // Coincident bodies always count as touching
    a_coin_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.coincident |-> o_res.touching)
        else $error("coincident result without touching");

    // Every accepted request yields a result after the fixed latency
    a_req_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_strobe)
        else $error("accepted request produced no result");

    // No result without a request accepted at the matching cycle
    a_res_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without a matching request");

endmodule

// ===== tb/sv/tb_pairwise_gravity_velocity_update.sv =====
// ----------------------------------------------------------------------------
// tb_pairwise_gravity_velocity_update - self-checking bench for the gravity kick
// Drives body pairs through the request port under several gravity gains.
// Every result is checked field by field against a wide-integer predictor
// or a hand-typed value. Random gaps are placed between requests.
// ----------------------------------------------------------------------------
module tb_pairwise_gravity_velocity_update;
    timeunit 1ns;
    timeprecision 1ps;
    import pgv_pkg::*;

    localparam int unsigned LATENCY    = 140;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned N_PHASES   = 8;
    localparam int unsigned PHASE_LEN  = 100;

    typedef struct {
        t_pgv_in  req;
        bit       typed;
        t_pgv_out res;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_pgv_in           i_req = '0;
    logic              i_cfg_we = 1'b0;
    logic [31:0]       i_cfg_wdata = '0;
    logic              o_strobe;
    t_pgv_out          o_res;

    logic [31:0]       gain_model = GAIN_RESET;
    t_pgv_out          pending_kicks[$];
    int unsigned       mismatches = 0;
    int unsigned       idle_cycles = 0;
    t_row              directed[$];

    pairwise_gravity_velocity_update dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Floor square root of the squared separation
    function automatic logic [33:0] root_floor(logic [127:0] s);
        logic [33:0]  r;
        logic [33:0]  c;
        logic [127:0] cc;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c  = r | (34'd1 << b);
            cc = 128'(c) * 128'(c);
            if (cc <= s) r = c;
        end
        return r;
    endfunction

    // Clamp a wide velocity into signed 32 bits
    function automatic logic [31:0] clamp_vel(longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return VEL_MAX;
        if (v < -longint'(64'h8000_0000)) return VEL_MIN;
        return v[31:0];
    endfunction

    // Work out new velocities and flags for one body pair
    function automatic t_pgv_out predict_kick(t_pgv_in p, logic [31:0] g);
        t_pgv_out     o;
        longint       ex, ey, ax, ay, v1x, v1y, v2x, v2y;
        logic [127:0] s, rsum, k, q, fx, fy;
        logic [33:0]  d;
        logic [63:0]  force_raw;
        ex   = longint'(p.first_pos_x) - longint'(p.second_pos_x);
        ey   = longint'(p.first_pos_y) - longint'(p.second_pos_y);
        ax   = ex < 0 ? -ex : ex;
        ay   = ey < 0 ? -ey : ey;
        s    = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        rsum = 128'(p.first_radius) + 128'(p.second_radius);
        v1x  = longint'(p.first_vel_x);
        v1y  = longint'(p.first_vel_y);
        v2x  = longint'(p.second_vel_x);
        v2y  = longint'(p.second_vel_y);
        o.touching   = (s <= rsum * rsum);
        o.coincident = (s == 0);
        if (s != 0) begin
            d = root_floor(s);
            k = 128'(g) * 128'(p.first_mass) * 128'(p.second_mass);
            q = k / 128'(d);
            q = q / 128'(d);
            force_raw = (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
            fx = 128'(force_raw) * 128'(ax) / 128'(d);
            fy = 128'(force_raw) * 128'(ay) / 128'(d);
            if (fx > 128'(COMP_MAX)) fx = 128'(COMP_MAX);
            if (fy > 128'(COMP_MAX)) fy = 128'(COMP_MAX);
            if (ex < 0) begin
                v1x += longint'(fx[32:0]);
                v2x -= longint'(fx[32:0]);
            end else begin
                v1x -= longint'(fx[32:0]);
                v2x += longint'(fx[32:0]);
            end
            if (ey < 0) begin
                v1y += longint'(fy[32:0]);
                v2y -= longint'(fy[32:0]);
            end else begin
                v1y -= longint'(fy[32:0]);
                v2y += longint'(fy[32:0]);
            end
        end
        o.new_first_vel_x  = clamp_vel(v1x);
        o.new_first_vel_y  = clamp_vel(v1y);
        o.new_second_vel_x = clamp_vel(v2x);
        o.new_second_vel_y = clamp_vel(v2y);
        return o;
    endfunction

    // Random pair: mostly close bodies with masses and radii over many scales
    function automatic t_pgv_in random_pair();
        t_pgv_in p;
        int      mode;
        mode = $urandom_range(0, 15);
        p.first_pos_x   = $urandom;
        p.first_pos_y   = $urandom;
        p.second_pos_x  = $urandom;
        p.second_pos_y  = $urandom;
        if (mode >= 4) begin
            p.second_pos_x = p.first_pos_x + ($urandom >> $urandom_range(8, 31))
                             - ($urandom >> $urandom_range(8, 31));
            p.second_pos_y = p.first_pos_y + ($urandom >> $urandom_range(8, 31))
                             - ($urandom >> $urandom_range(8, 31));
        end
        if (mode == 0) begin
            p.second_pos_x = p.first_pos_x;
            p.second_pos_y = p.first_pos_y;
        end
        p.first_vel_x   = $urandom;
        p.first_vel_y   = $urandom;
        p.second_vel_x  = $urandom;
        p.second_vel_y  = $urandom;
        p.first_mass    = $urandom >> $urandom_range(0, 31);
        p.second_mass   = $urandom >> $urandom_range(0, 31);
        p.first_radius  = $urandom >> $urandom_range(0, 31);
        p.second_radius = $urandom >> $urandom_range(0, 31);
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Present one request, hold until taken, then record its expectation
    task automatic send_pair(t_pgv_in p, bit typed, t_pgv_out res);
        int gap;
        i_req <= p;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_kicks.push_back(typed ? res : predict_kick(p, gain_model));
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write the gain once everything in flight has come back
    task automatic set_gain(logic [31:0] g);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_kicks.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        gain_model = g;
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_pgv_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_kicks.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                mismatches++;
            end else begin
                want = pending_kicks.pop_front();
                if (o_res.new_first_vel_x !== want.new_first_vel_x)
                    report_mismatch("new_first_vel_x", o_res.new_first_vel_x,
                                    want.new_first_vel_x);
                if (o_res.new_first_vel_y !== want.new_first_vel_y)
                    report_mismatch("new_first_vel_y", o_res.new_first_vel_y,
                                    want.new_first_vel_y);
                if (o_res.new_second_vel_x !== want.new_second_vel_x)
                    report_mismatch("new_second_vel_x", o_res.new_second_vel_x,
                                    want.new_second_vel_x);
                if (o_res.new_second_vel_y !== want.new_second_vel_y)
                    report_mismatch("new_second_vel_y", o_res.new_second_vel_y,
                                    want.new_second_vel_y);
                if (o_res.touching !== want.touching)
                    report_mismatch("touching", 32'(o_res.touching), 32'(want.touching));
                if (o_res.coincident !== want.coincident)
                    report_mismatch("coincident", 32'(o_res.coincident),
                                    32'(want.coincident));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("pairwise_gravity_velocity_update regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Directed table: typed rows are read straight off the behaviour
    function automatic void build_table();
        t_row r;
        // coincident bodies with extreme velocities pass straight through
        r.req = '{32'sh1234_5678, 32'sh8000_0000, 32'sh1234_5678, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0};
        r.typed = 1'b1;
        r.res = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  1'b1, 1'b1};
        directed.push_back(r);
        // zero mass: no force, bodies apart
        r.req = '{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0,
                  32'sh0000_0100, -32'sh0000_0200, 32'sh7FFF_FFFF, 32'sh0,
                  32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
        r.res = '{32'sh0000_0100, -32'sh0000_0200, 32'sh7FFF_FFFF, 32'sh0, 1'b0, 1'b0};
        directed.push_back(r);
        // huge force on adjacent bodies drives x to both rails
        r.req = '{32'sh0, 32'sh5, 32'sh1, 32'sh5,
                  32'sh8000_0000, 32'sh0000_0042, 32'sh7FFF_FFFF, -32'sh0000_0042,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0};
        r.res = '{32'sh7FFF_FFFF, 32'sh0000_0042, 32'sh8000_0000, -32'sh0000_0042,
                  1'b1, 1'b0};
        directed.push_back(r);
        r.typed = 1'b0;
        // opposite position extremes, heaviest masses
        r.req = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh0, 32'sh0, 32'sh0, 32'sh0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        directed.push_back(r);
        // separation exactly the sum of radii, then just beyond it
        r.req = '{32'sh0003_0000, 32'sh0, 32'sh0, 32'sh0,
                  32'sh0, 32'sh0, 32'sh0, 32'sh0,
                  32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000};
        directed.push_back(r);
        r.req.first_pos_x = 32'sh0003_0001;
        directed.push_back(r);
        // diagonal pair, negative separation, moderate force
        r.req = '{-32'sh0002_0000, -32'sh0004_0000, 32'sh0001_0000, 32'sh0000_0000,
                  32'sh7FFF_FF00, 32'sh8000_0100, 32'sh0, 32'sh1,
                  32'h0100_0000, 32'h0080_0000, 32'h0, 32'h0004_0000};
        directed.push_back(r);
        // far apart, tiny masses: force rounds away
        r.req = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 32'sh0,
                  32'sh1, -32'sh1, 32'sh0, 32'sh0,
                  32'h1, 32'h1, 32'h0, 32'h0};
        directed.push_back(r);
    endfunction

    initial begin
        logic [31:0] gains[N_PHASES];
        gains = '{32'h0, 32'hFFFF_FFFF, 32'h1, GAIN_RESET, 32'h0000_0100,
                  32'h0100_0000, 32'h0, 32'h0};
        gains[6] = $urandom;
        gains[7] = $urandom >> 8;
        build_table();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at the reset gain
        foreach (directed[i])
            send_pair(directed[i].req, directed[i].typed, directed[i].res);

        // random phases, each under its own gain
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_gain(gains[ph]);
            for (int n = 0; n < PHASE_LEN; n++)
                send_pair(random_pair(), 1'b0, '0);
        end

        // drain, then give the pipeline time to show any stray result
        start <= 1'b0;
        while (pending_kicks.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("pairwise_gravity_velocity_update regression: pass");
        end else begin
            $display("pairwise_gravity_velocity_update regression: fail");
        end
        $finish;
    end

endmodule
